// ----- sv/pnp4_pkg.sv -----
// Shared widths, codes and default sizes for the 4-bit palette quantizer.
package pnp4_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int unsigned PaletteSize = 16;
    localparam int unsigned MaxWidth    = 320;
    localparam int unsigned MaxHeight   = 240;

    // Largest palette the index field can address.
    localparam int unsigned PalMax   = 16;
    localparam int unsigned PalIdxW  = 4;

    localparam int unsigned ColorW   = 24;
    localparam int unsigned RowW     = 8;
    localparam int unsigned ColW     = 9;
    localparam int unsigned WidthW   = 9;
    localparam int unsigned HeightW  = 8;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned AddrW    = 16;
    localparam int unsigned DistW    = 32;
    // One bit above the address so the halving keeps every needed bit.
    localparam int unsigned FlipW    = AddrW + 1;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 9;

    typedef enum logic [CfgIdxW-1:0] {
        CfgKey    = 2'd0,
        CfgWidth  = 2'd1,
        CfgHeight = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        FuncWrite   = 1'b0,
        FuncConvert = 1'b1
    } t_func;

endpackage

// ----- sv/pnp4_if.sv -----
// Request, result and configuration channel interfaces of the quantizer.
interface pnp4_req_if;
    import pnp4_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [PalIdxW-1:0]  entry_index;
    logic [ColorW-1:0]   entry_color;
    logic [ColorW-1:0]   pixel_left;
    logic [ColorW-1:0]   pixel_right;
    logic [RowW-1:0]     row;
    logic [ColW-1:0]     column;
    modport source (output valid, func, entry_index, entry_color, pixel_left,
                    pixel_right, row, column, input ready);
    modport sink   (input valid, func, entry_index, entry_color, pixel_left,
                    pixel_right, row, column, output ready);
endinterface

interface pnp4_rsp_if;
    import pnp4_pkg::*;
    logic              valid;
    logic              ready;
    logic [ByteW-1:0]  packed_byte;
    logic [AddrW-1:0]  byte_address;
    modport source (output valid, packed_byte, byte_address, input ready);
    modport sink   (input valid, packed_byte, byte_address, output ready);
endinterface

interface pnp4_cfg_if;
    import pnp4_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pnp4_nearest.sv -----
// Pipelined nearest-palette-entry search for one pixel: distance, square, 4-level tree.
module pnp4_nearest #(
    parameter int unsigned PALETTE_SIZE = pnp4_pkg::PaletteSize
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [pnp4_pkg::ColorW-1:0]    i_palette [PALETTE_SIZE],
    input  logic [pnp4_pkg::ColorW-1:0]    i_pixel,
    output logic [pnp4_pkg::PalIdxW-1:0]   o_index
);
    import pnp4_pkg::*;

    typedef struct packed {
        logic               v;
        logic [PalIdxW-1:0] idx;
        logic [DistW-1:0]   dsq;
    } t_cand;

    // The lower index sits on the left, so a tie keeps it.
    function automatic t_cand pick(input t_cand a, input t_cand b);
        t_cand res;
        if (a.v && (!b.v || a.dsq <= b.dsq)) begin
            res = a;
        end else begin
            res = b;
        end
        return res;
    endfunction

    logic [PalMax-1:0]    w_leaf_v;
    logic [ColorW-1:0]    w_abs [PalMax];
    logic [ColorW-1:0]    r_abs [PalMax];
    logic [DistW-1:0]     r_sq  [PalMax];
    t_cand                r_l1  [PalMax/2];
    t_cand                r_l2  [PalMax/4];
    t_cand                r_l3  [PalMax/8];
    t_cand                r_l4;

    // Entry 0 is never a candidate, nor is any slot beyond the palette.
    for (genvar i = 0; i < PalMax; i++) begin : g_leaf
        if (i >= 1 && i < PALETTE_SIZE) begin : g_used
            logic [ColorW:0] w_diff;
            assign w_diff      = {1'b0, i_palette[i]} - {1'b0, i_pixel};
            assign w_abs[i]    = w_diff[ColorW] ? ColorW'(-w_diff) : w_diff[ColorW-1:0];
            assign w_leaf_v[i] = 1'b1;
        end else begin : g_unused
            assign w_abs[i]    = '0;
            assign w_leaf_v[i] = 1'b0;
        end
    end

    // The low 32 bits of the square match the wrapped square of the difference.
    for (genvar i = 0; i < PalMax; i++) begin : g_sq
        logic [2*ColorW-1:0] w_full;
        assign w_full = r_abs[i] * r_abs[i];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_abs[i] <= w_abs[i];
                r_sq[i]  <= w_full[DistW-1:0];
            end
        end
    end

    for (genvar j = 0; j < PalMax/2; j++) begin : g_l1
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_l1[j] <= pick({w_leaf_v[2*j],   PalIdxW'(2*j),   r_sq[2*j]},
                                {w_leaf_v[2*j+1], PalIdxW'(2*j+1), r_sq[2*j+1]});
            end
        end
    end

    for (genvar j = 0; j < PalMax/4; j++) begin : g_l2
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_l2[j] <= pick(r_l1[2*j], r_l1[2*j+1]);
            end
        end
    end

    for (genvar j = 0; j < PalMax/8; j++) begin : g_l3
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_l3[j] <= pick(r_l2[2*j], r_l2[2*j+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l4 <= pick(r_l3[0], r_l3[1]);
        end
    end

    assign o_index = r_l4.idx;

endmodule

// ----- sv/palette_nearest_pack4_top.sv -----
// Top level of the 4-bit nearest-color palette quantizer with bitmap row flip.
//
// Takes one request per clock unless a finished result waits unclaimed: a palette
// write (func 0, no result) or a pixel pair (func 1, one result). Each pixel of a
// pair maps to the closest palette entry 1..N-1 by wrapped squared difference of
// the packed colors, lowest index on a tie; an index equal to the key becomes 0, and
// the pair is packed left-high into one byte together with its row-flipped byte
// address. A pixel pair passes through the absolute difference, the per-entry
// square, the four-level minimum tree and the output register, each its own register
// stage. The whole pipeline holds while a result waits, so one pair per clock is
// sustained whenever the result side takes one per clock. A palette write is seen
// by every pair taken after it. Configuration writes are always taken.
module palette_nearest_pack4_top #(
    parameter int unsigned PALETTE_SIZE = pnp4_pkg::PaletteSize,
    parameter int unsigned MAX_WIDTH    = pnp4_pkg::MaxWidth,
    parameter int unsigned MAX_HEIGHT   = pnp4_pkg::MaxHeight
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnp4_req_if.sink    i_req,
    pnp4_rsp_if.source  o_rsp,
    pnp4_cfg_if.sink    i_cfg
);
    import pnp4_pkg::*;

    localparam int unsigned NumStages = 7;
    localparam logic [WidthW-1:0]  WidthReset  = WidthW'(MAX_WIDTH);
    localparam logic [HeightW-1:0] HeightReset = HeightW'(MAX_HEIGHT);

    logic [PalIdxW-1:0]   r_key;
    logic [WidthW-1:0]    r_width;
    logic [HeightW-1:0]   r_height;
    logic [ColorW-1:0]    r_palette [PALETTE_SIZE];
    logic [NumStages-1:0] r_vld;

    logic                 w_en;
    logic                 w_acc;
    logic                 w_conv;
    logic                 w_pal_wr;

    logic [FlipW-1:0]     w_flip;
    logic [FlipW-1:0]     r_flip;
    logic [ColW-1:0]      r_col1;
    logic [FlipW-1:0]     w_prod;
    logic [FlipW-1:0]     r_prod;
    logic [ColW-1:0]      r_col2;
    logic [FlipW-1:0]     w_sum;
    logic [AddrW-1:0]     r_addr_d [4];

    logic [PalIdxW-1:0]   w_idx_hi;
    logic [PalIdxW-1:0]   w_idx_lo;
    logic [PalIdxW-1:0]   w_key_hi;
    logic [PalIdxW-1:0]   w_key_lo;
    logic [ByteW-1:0]     r_byte;
    logic [AddrW-1:0]     r_baddr;

    // Every stage advances together unless a finished result is still unclaimed.
    assign w_en        = !r_vld[NumStages-1] || o_rsp.ready;
    assign i_req.ready = w_en;
    assign w_acc       = i_req.valid && w_en;
    assign w_conv      = w_acc && (i_req.func == FuncConvert);
    assign w_pal_wr    = w_acc && (i_req.func == FuncWrite)
                         && ({1'b0, i_req.entry_index} < (PalIdxW+1)'(PALETTE_SIZE));

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_width  <= WidthReset;
            r_height <= HeightReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CfgKey:    r_key    <= i_cfg.data[PalIdxW-1:0];
                CfgWidth:  r_width  <= i_cfg.data[WidthW-1:0];
                CfgHeight: r_height <= i_cfg.data[HeightW-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PALETTE_SIZE; k++) begin
            if (w_pal_wr && i_req.entry_index == PalIdxW'(k)) begin
                r_palette[k] <= i_req.entry_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NumStages-2:0], w_conv};
        end
    end

    pnp4_nearest #(.PALETTE_SIZE(PALETTE_SIZE)) u_near_left (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_palette (r_palette),
        .i_pixel   (i_req.pixel_left),
        .o_index   (w_idx_hi)
    );

    pnp4_nearest #(.PALETTE_SIZE(PALETTE_SIZE)) u_near_right (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_palette (r_palette),
        .i_pixel   (i_req.pixel_right),
        .o_index   (w_idx_lo)
    );

    // Only the low 17 bits of the address sum survive the halving and truncation,
    // so the wrapped row term is carried at that width.
    assign w_flip = FlipW'(r_height) - FlipW'(i_req.row) - FlipW'(1);
    assign w_prod = r_flip * {r_width[WidthW-1:1], 1'b0};
    assign w_sum  = r_prod + FlipW'(r_col2) + FlipW'(1);

    assign w_key_hi = (w_idx_hi == r_key) ? '0 : w_idx_hi;
    assign w_key_lo = (w_idx_lo == r_key) ? '0 : w_idx_lo;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flip      <= w_flip;
            r_col1      <= i_req.column;
            r_prod      <= w_prod;
            r_col2      <= r_col1;
            r_addr_d[0] <= w_sum[AddrW:1];
            r_addr_d[1] <= r_addr_d[0];
            r_addr_d[2] <= r_addr_d[1];
            r_addr_d[3] <= r_addr_d[2];
            r_byte      <= {w_key_hi, w_key_lo};
            r_baddr     <= r_addr_d[3];
        end
    end

    assign o_rsp.valid        = r_vld[NumStages-1];
    assign o_rsp.packed_byte  = r_byte;
    assign o_rsp.byte_address = r_baddr;

endmodule
